>>> rtl/core/bounded_ordered_list_defines.svh
// assertion macros for the bounded ordered list checker
// no dependencies; clock and reset are taken from the scope of use
`ifndef BOUNDED_ORDERED_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_DEFINES_SVH

// same-cycle implication
`define BOL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BOL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bol_pkg.sv
// shared types and codes for the bounded ordered list
// used by the top level and its checker; depends on nothing
package bol_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W     = 3;
   localparam int POS_W     = 8;
   localparam int HANDLE_W  = 32;
   localparam int STATUS_W  = 3;
   localparam int ECOUNT_W  = 8;

   localparam logic [CMD_W-1:0] CMD_APPEND      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE_LAST = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_AT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ        = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OOB       = 3'd4;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] read_handle;
      logic [ECOUNT_W-1:0] entry_count;
   } rsp_type;

endpackage

>>> rtl/core/bounded_ordered_list.sv
// bounded ordered list: fixed-capacity list of handles in parallel slot registers
// depends on bol_pkg for codes, widths and the response struct
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | command, position, entry_handle
//   rsp     | out       | rsp_valid/stall   | status, read_handle, entry_count
//
// one request per cycle while req_stall is low; its response is registered in the
// output register, or in the skid entry while rsp_stall holds the output; all slots
// update in parallel in the accepting cycle, so back-to-back requests see the list
// left by the one before; a two-entry response buffer (output register plus skid)
// parts the two sides; req_stall rises only while both entries are held
// synchronous reset clears all slots, the count and both buffer valid flags
module bounded_ordered_list #(
   parameter int DEPTH = bol_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bol_pkg::CMD_W-1:0]     req_command,
   input  logic [bol_pkg::POS_W-1:0]     req_position,
   input  logic [bol_pkg::HANDLE_W-1:0]  req_entry_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bol_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bol_pkg::HANDLE_W-1:0]  rsp_read_handle,
   output logic [bol_pkg::ECOUNT_W-1:0]  rsp_entry_count
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EXT_W = bol_pkg::POS_W + 1;

   logic [bol_pkg::HANDLE_W-1:0] slots_ff [DEPTH];
   logic [bol_pkg::HANDLE_W-1:0] slots_in [DEPTH];
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic [CNT_W-1:0]             cnt_m1;
   logic [bol_pkg::POS_W-1:0]    pos_m1;
   logic [EXT_W-1:0]             pos_ext;
   logic [EXT_W-1:0]             pos_m1_ext;
   logic [EXT_W-1:0]             cnt_ext;
   logic                         full;
   logic                         empty;
   logic                         req_accept;
   logic                         rsp_take;

   bol_pkg::rsp_type rsp_next;
   bol_pkg::rsp_type out_ff;
   bol_pkg::rsp_type skid_ff;
   logic             out_valid_ff;
   logic             skid_valid_ff;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = out_valid_ff && !rsp_stall;

   always_comb begin
      pos_ext    = EXT_W'(req_position);
      cnt_ext    = EXT_W'(count_ff);
      pos_m1     = req_position - 8'd1;
      pos_m1_ext = EXT_W'(pos_m1);
      cnt_m1     = count_ff - 1'b1;
      full       = cnt_ext >= EXT_W'(DEPTH);
      empty      = (count_ff == '0);

      slots_in             = slots_ff;
      count_in             = count_ff;
      rsp_next.status      = bol_pkg::ST_OK;
      rsp_next.read_handle = '0;

      case (req_command)
         bol_pkg::CMD_APPEND: begin
            if (full) begin
               rsp_next.status = bol_pkg::ST_OVERFLOW;
            end else begin
               slots_in[count_ff[IDX_W-1:0]] = req_entry_handle;
               count_in = count_ff + 1'b1;
            end
         end
         bol_pkg::CMD_INSERT: begin
            if (full) begin
               rsp_next.status = bol_pkg::ST_OVERFLOW;
            end else if (req_position == '0 || pos_ext > cnt_ext + 1'b1) begin
               rsp_next.status = bol_pkg::ST_BAD_POS;
            end else begin
               // entries from the position up to the old end move up one slot
               for (int i = 0; i < DEPTH; i++) begin
                  if (EXT_W'(i) == pos_m1_ext) begin
                     slots_in[i] = req_entry_handle;
                  end else if (EXT_W'(i) > pos_m1_ext && EXT_W'(i) <= cnt_ext) begin
                     slots_in[i] = slots_ff[(i == 0) ? 0 : i - 1];
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         bol_pkg::CMD_REMOVE_LAST: begin
            if (empty) begin
               rsp_next.status = bol_pkg::ST_UNDERFLOW;
            end else begin
               slots_in[cnt_m1[IDX_W-1:0]] = '0;
               count_in = cnt_m1;
            end
         end
         bol_pkg::CMD_REMOVE_AT: begin
            if (req_position == '0 || pos_ext > cnt_ext) begin
               rsp_next.status = bol_pkg::ST_OOB;
            end else begin
               // slots past the end are always null, so shifting the whole tail is exact
               for (int i = 0; i < DEPTH; i++) begin
                  if (EXT_W'(i) >= pos_m1_ext) begin
                     slots_in[i] = (i == DEPTH - 1) ? '0
                                 : slots_ff[(i == DEPTH - 1) ? i : i + 1];
                  end
               end
               count_in = cnt_m1;
            end
         end
         bol_pkg::CMD_READ: begin
            if (req_position == '0 || pos_ext > cnt_ext) begin
               rsp_next.status = bol_pkg::ST_OOB;
            end else begin
               rsp_next.read_handle = slots_ff[pos_m1[IDX_W-1:0]];
            end
         end
         default: begin
         end
      endcase

      rsp_next.entry_count = bol_pkg::ECOUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            slots_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (req_accept) begin
         slots_ff <= slots_in;
         count_ff <= count_in;
      end
   end

   // response buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // response buffer payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_next;
      end else if (req_accept) begin
         skid_ff <= rsp_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_read_handle = out_ff.read_handle;
   assign rsp_entry_count = out_ff.entry_count;

endmodule

>>> rtl/core/bol_checker.sv
// port-level checker for the bounded ordered list, with its bind
// depends on bol_pkg and bounded_ordered_list_defines.svh
`include "bounded_ordered_list_defines.svh"

module bol_checker #(
   parameter int DEPTH = bol_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bol_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bol_pkg::HANDLE_W-1:0]  rsp_read_handle,
   input logic [bol_pkg::ECOUNT_W-1:0]  rsp_entry_count
);

   `BOL_ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid, "rsp dropped while stalled")

   `BOL_ASSERT_NEXT(a_rsp_payload_holds, rsp_valid && rsp_stall, $stable(rsp_status) && $stable(rsp_read_handle) && $stable(rsp_entry_count), "rsp payload changed while stalled")

   `BOL_ASSERT_IMPL(a_handle_only_on_ok, rsp_valid && rsp_read_handle != '0, rsp_status == bol_pkg::ST_OK, "read handle on failed request")

   `BOL_ASSERT_IMPL(a_count_bounded, rsp_valid, 32'(rsp_entry_count) <= DEPTH, "entry count beyond capacity")

   // request side only stalls while a response is waiting
   `BOL_ASSERT_IMPL(a_stall_needs_rsp, req_stall, rsp_valid, "req stalled with no response held")

endmodule

bind bounded_ordered_list bol_checker #(.DEPTH(DEPTH)) u_bol_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_read_handle  (rsp_read_handle),
   .rsp_entry_count  (rsp_entry_count)
);
